### hw/rtl/hsec_pkg.sv
package hsec_pkg;

    localparam int FIELD_W       = 64;
    localparam int COUNT_W_DEF   = 64;
    localparam int SHIFT_W       = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int STATUS_W      = 2;

    localparam logic [SHIFT_W-1:0] RADIX_RST = SHIFT_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RADIX  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_RADIX  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_RADIX = CFG_IDX_W'(2);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADARG   = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

endpackage

### hw/rtl/hierarchical_slot_epoch_clock.sv
// An accepted request is held in the input register; its result is written into the
// output register once the output stage is free.
// Throughput: one request per cycle while the output is not stalled; the four-level
// carry chain settles in one pass between the input register and the result register,
// and the counts update in that same cycle, so the next request sees them at once.
// Reset (synchronous, active low): counts cleared, radix shifts set to 8, both
// stages emptied.
module hierarchical_slot_epoch_clock #(
    parameter int COUNT_WIDTH = hsec_pkg::COUNT_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hsec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hsec_pkg::SHIFT_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hsec_pkg::FIELD_W-1:0]      i_stride,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [hsec_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_slot_roll,
    output logic                              o_epoch_roll,
    output logic                              o_era_roll,
    output logic [hsec_pkg::FIELD_W-1:0]      o_tick_now,
    output logic [hsec_pkg::FIELD_W-1:0]      o_slot_now,
    output logic [hsec_pkg::FIELD_W-1:0]      o_epoch_now,
    output logic [hsec_pkg::FIELD_W-1:0]      o_era_now
);
    import hsec_pkg::*;

    localparam int W = COUNT_WIDTH;

    typedef logic [W-1:0] t_cnt;

    logic [SHIFT_W-1:0] r_tick_sh, r_slot_sh, r_epoch_sh;
    t_cnt               r_tick, r_slot, r_epoch, r_era;

    logic               r_in_valid;
    logic [FIELD_W-1:0] r_stride;

    logic               r_out_valid;
    t_status            r_status;
    logic               r_fs, r_fe, r_fr;
    logic [FIELD_W-1:0] r_tick_o, r_slot_o, r_epoch_o, r_era_o;

    logic               advance;
    t_status            n_status;
    logic               n_fs, n_fe, n_fr;
    t_cnt               n_tick, n_slot, n_epoch, n_era;

    logic               stride_hi;
    logic [W:0]         sum0, sum1, sum2, sum3;
    t_cnt               c1, c2, c3;
    t_cnt               m0, m1, m2;

    function automatic t_cnt lvl_mask(input t_cnt v, input logic [SHIFT_W-1:0] sh);
        t_cnt res;
        if ({1'b0, sh} >= (SHIFT_W+1)'(W)) begin
            res = v;
        end else begin
            res = v & ~({W{1'b1}} << sh);
        end
        return res;
    endfunction

    function automatic t_cnt lvl_carry(input t_cnt v, input logic [SHIFT_W-1:0] sh);
        t_cnt res;
        if ({1'b0, sh} >= (SHIFT_W+1)'(W)) begin
            res = '0;
        end else begin
            res = v >> sh;
        end
        return res;
    endfunction

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // carry chain
    assign stride_hi = |(r_stride >> W);
    assign sum0 = {1'b0, r_tick} + {1'b0, r_stride[W-1:0]};
    assign m0   = lvl_mask(sum0[W-1:0], r_tick_sh);
    assign c1   = lvl_carry(sum0[W-1:0], r_tick_sh);
    assign sum1 = {1'b0, r_slot} + {1'b0, c1};
    assign m1   = lvl_mask(sum1[W-1:0], r_slot_sh);
    assign c2   = lvl_carry(sum1[W-1:0], r_slot_sh);
    assign sum2 = {1'b0, r_epoch} + {1'b0, c2};
    assign m2   = lvl_mask(sum2[W-1:0], r_epoch_sh);
    assign c3   = lvl_carry(sum2[W-1:0], r_epoch_sh);
    assign sum3 = {1'b0, r_era} + {1'b0, c3};

    always_comb begin
        n_status = ST_OK;
        n_fs     = 1'b0;
        n_fe     = 1'b0;
        n_fr     = 1'b0;
        if (r_stride == '0) begin
            n_status = ST_BADARG;
        end else if (stride_hi || sum0[W]) begin
            n_status = ST_OVERFLOW;
        end else if (c1 != '0) begin
            if (sum1[W]) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_fs = 1'b1;
                if (c2 != '0) begin
                    if (sum2[W]) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_fe = 1'b1;
                        if (c3 != '0) begin
                            if (sum3[W]) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_fr = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        n_tick  = r_tick;
        n_slot  = r_slot;
        n_epoch = r_epoch;
        n_era   = r_era;
        if (n_status == ST_OK) begin
            n_tick = m0;
            if (n_fs) begin
                n_slot = m1;
            end
            if (n_fe) begin
                n_epoch = m2;
            end
            if (n_fr) begin
                n_era = sum3[W-1:0];
            end
        end else begin
            n_fs = 1'b0;
            n_fe = 1'b0;
            n_fr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_sh   <= RADIX_RST;
            r_slot_sh   <= RADIX_RST;
            r_epoch_sh  <= RADIX_RST;
            r_tick      <= '0;
            r_slot      <= '0;
            r_epoch     <= '0;
            r_era       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TICK_RADIX:  r_tick_sh  <= i_cfg_data;
                    CFG_SLOT_RADIX:  r_slot_sh  <= i_cfg_data;
                    CFG_EPOCH_RADIX: r_epoch_sh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_tick      <= n_tick;
                r_slot      <= n_slot;
                r_epoch     <= n_epoch;
                r_era       <= n_era;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_stride <= i_stride;
        end
        if (advance) begin
            r_status  <= n_status;
            r_fs      <= n_fs;
            r_fe      <= n_fe;
            r_fr      <= n_fr;
            r_tick_o  <= FIELD_W'(n_tick);
            r_slot_o  <= FIELD_W'(n_slot);
            r_epoch_o <= FIELD_W'(n_epoch);
            r_era_o   <= FIELD_W'(n_era);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_roll  = r_fs;
    assign o_epoch_roll = r_fe;
    assign o_era_roll   = r_fr;
    assign o_tick_now   = r_tick_o;
    assign o_slot_now   = r_slot_o;
    assign o_epoch_now  = r_epoch_o;
    assign o_era_now    = r_era_o;

`ifndef SYNTHESIS
    a_err_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (!r_fs && !r_fe && !r_fr))
        else $error("boundary flag set on failed request");

    a_flag_nesting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fr) |-> (r_fe && r_fs))
        else $error("era boundary without epoch and slot boundary");

    a_badarg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_stride == '0) |=> (r_tick == $past(r_tick) && r_era == $past(r_era)))
        else $error("zero stride changed the counts");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");
`endif

endmodule
